### sv/tsfb_pkg.sv
// Package with constants, types and the CRC byte step for the timesync frame builder.
package tsfb_pkg;

    localparam int unsigned FRAME_LEN = 28;

    localparam logic [7:0] START_BYTE  = 8'hfd;
    localparam logic [7:0] PAYLOAD_LEN = 8'd16;
    localparam logic [23:0] MSG_ID     = 24'd111;
    localparam logic [7:0] CRC_SEED    = 8'd34;
    localparam logic [15:0] CRC_INIT   = 16'hffff;

    localparam logic [7:0] SYSTEM_ID_RESET    = 8'd255;
    localparam logic [7:0] COMPONENT_ID_RESET = 8'd190;

    localparam logic [4:0] POS_START     = 5'd0;
    localparam logic [4:0] POS_LEN       = 5'd1;
    localparam logic [4:0] POS_SEQ       = 5'd4;
    localparam logic [4:0] POS_SYS       = 5'd5;
    localparam logic [4:0] POS_COMP      = 5'd6;
    localparam logic [4:0] POS_MSG0      = 5'd7;
    localparam logic [4:0] POS_MSG1      = 5'd8;
    localparam logic [4:0] POS_MSG2      = 5'd9;
    localparam logic [4:0] POS_STAMP     = 5'd18;
    localparam logic [4:0] POS_BODY_LAST = 5'd25;
    localparam logic [4:0] POS_CRC_LO    = 5'd26;
    localparam logic [4:0] POS_CRC_HI    = 5'd27;

    localparam logic REG_SYSTEM_ID    = 1'b0;
    localparam logic REG_COMPONENT_ID = 1'b1;

    typedef struct packed {
        logic init;
        logic step;
        logic seed;
    } t_crc_ctl;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'h0};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
    endfunction

endpackage

### sv/tsfb_if.sv
// Interfaces for the request channel and the frame byte channel.
interface tsfb_req_if;
    logic               valid;
    logic               ready;
    logic [7:0]         sequence_req;
    logic signed [63:0] stamp;

    modport source (output valid, output sequence_req, output stamp, input ready);
    modport sink (input valid, input sequence_req, input stamp, output ready);
endinterface

interface tsfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink (input valid, input frame_byte, input last, output ready);
endinterface

### sv/timesync_frame_builder.sv
// Top level of the timesync frame builder: request intake, byte sequencer and register port.
// Each accepted request yields a 28-byte TIMESYNC packet, one byte per transfer on the
// frame channel, with last set on the final checksum byte. Bytes leave at one per cycle
// when the sink keeps ready high. The next request is accepted in the cycle that forms the
// final byte of the current packet. The timestamp is held in a shift register that moves
// one byte per cycle while stamp bytes are sent and the frame channel is not stalled, and
// the checksum is updated one byte per cycle while the frame channel is not stalled.
// System and component ids are written through the APB port at addresses 0 and 4.
module timesync_frame_builder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tsfb_req_if.sink           i_req,
    tsfb_byte_if.source        o_frame,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tsfb_pkg::*;

    logic        r_busy;
    logic [4:0]  r_pos;
    logic [7:0]  r_seq;
    logic [63:0] r_stamp;
    logic [7:0]  r_system_id;
    logic [7:0]  r_component_id;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_adv;
    logic        w_accept;
    logic [7:0]  w_byte;
    logic [15:0] w_crc;
    t_crc_ctl    w_crc_ctl;

    assign w_adv    = r_busy && (!r_out_valid || o_frame.ready);
    assign i_req.ready = !r_busy || (w_adv && (r_pos == POS_CRC_HI));
    assign w_accept = i_req.valid && i_req.ready;

    always_comb begin
        case (r_pos)
            POS_START:  w_byte = START_BYTE;
            POS_LEN:    w_byte = PAYLOAD_LEN;
            POS_SEQ:    w_byte = r_seq;
            POS_SYS:    w_byte = r_system_id;
            POS_COMP:   w_byte = r_component_id;
            POS_MSG0:   w_byte = MSG_ID[7:0];
            POS_MSG1:   w_byte = MSG_ID[15:8];
            POS_MSG2:   w_byte = MSG_ID[23:16];
            POS_CRC_LO: w_byte = w_crc[7:0];
            POS_CRC_HI: w_byte = w_crc[15:8];
            default: begin
                if (r_pos >= POS_STAMP && r_pos <= POS_BODY_LAST) begin
                    w_byte = r_stamp[7:0];
                end else begin
                    w_byte = 8'h00;
                end
            end
        endcase
    end

    always_comb begin
        w_crc_ctl.init = w_accept;
        w_crc_ctl.step = w_adv && (r_pos >= POS_LEN) && (r_pos <= POS_BODY_LAST);
        w_crc_ctl.seed = w_adv && (r_pos == POS_BODY_LAST);
    end

    tsfb_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_byte  (w_byte),
        .o_crc   (w_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= POS_START;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_pos  <= POS_START;
            end else if (w_adv) begin
                if (r_pos == POS_CRC_HI) begin
                    r_busy <= 1'b0;
                    r_pos  <= POS_START;
                end else begin
                    r_pos <= r_pos + 5'd1;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seq   <= i_req.sequence_req;
            r_stamp <= i_req.stamp;
        end else if (w_adv && r_pos >= POS_STAMP && r_pos <= POS_BODY_LAST) begin
            r_stamp <= {8'h00, r_stamp[63:8]};
        end
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= (r_pos == POS_CRC_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_system_id    <= SYSTEM_ID_RESET;
            r_component_id <= COMPONENT_ID_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SYSTEM_ID:    r_system_id    <= pwdata[7:0];
                REG_COMPONENT_ID: r_component_id <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SYSTEM_ID:    prdata = {24'h000000, r_system_id};
            REG_COMPONENT_ID: prdata = {24'h000000, r_component_id};
            default:          prdata = 32'h00000000;
        endcase
    end

    assign pready = 1'b1;

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.last       = r_out_last;

endmodule

### sv/tsfb_crc.sv
// Byte-serial X.25 CRC accumulator with an optional seed byte step.
module tsfb_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsfb_pkg::t_crc_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [15:0]       o_crc
);
    import tsfb_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] w_after_byte;

    always_comb begin
        w_after_byte = i_ctl.step ? crc_step(r_crc, i_byte) : r_crc;
        n_crc = i_ctl.seed ? crc_step(w_after_byte, CRC_SEED) : w_after_byte;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule
